FILE: rtl/lks_pkg.sv
// Package for the Lehmer keystream XOR block: field widths, generator constants
// and the control struct passed to the generator.
// No dependencies; every other file imports this package.
package lks_pkg;

   // Field widths.
   localparam int WORD_W   = 32;
   localparam int NBYTES_W = 3;
   localparam int GEN_W    = 31;
   localparam int NLANES   = WORD_W / 8;

   // Number of generator bits XORed into the data word.
   localparam int KEY_BITS = 15;

   // Park-Miller minimal standard generator: x' = 16807 * x mod (2^31 - 1).
   localparam int MULT_W = 15;
   localparam int PROD_W = GEN_W + MULT_W;
   localparam logic [MULT_W-1:0] LCG_MULT   = MULT_W'(16807);
   localparam logic [GEN_W-1:0]  LCG_MOD    = {GEN_W{1'b1}};
   localparam logic [GEN_W-1:0]  ZERO_SUBST = GEN_W'(32'h1234_5987);

   // Control from the datapath to the generator.
   typedef struct packed {
      logic step;     // an item leaves the input register this cycle
      logic restart;  // reload from the seed before stepping
   } gen_ctl_type;

endpackage

FILE: rtl/lks_ifs.sv
// Handshake interfaces for the request and response channels of the
// Lehmer keystream XOR block. Depends on lks_pkg.
interface lks_req_if;
   import lks_pkg::*;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   data_word;
   logic [NBYTES_W-1:0] valid_bytes;
   logic                restart;

   modport source (output valid, output data_word, output valid_bytes, output restart,
                   input ready);
   modport sink   (input valid, input data_word, input valid_bytes, input restart,
                   output ready);
endinterface

interface lks_rsp_if;
   import lks_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] cipher_word;

   modport source (output valid, output cipher_word, input ready);
   modport sink   (input valid, input cipher_word, output ready);
endinterface

FILE: rtl/lks_gen.sv
// Park-Miller generator register with its combinational step: a constant multiply
// followed by a Mersenne fold. Depends on lks_pkg.
module lks_gen (
   input  logic                      clock,
   input  logic                      reset,
   input  lks_pkg::gen_ctl_type      ctl,
   input  logic [lks_pkg::GEN_W-1:0] seed,
   output logic [lks_pkg::GEN_W-1:0] gen_next
);
   import lks_pkg::*;

   logic [GEN_W-1:0]  gen_ff;
   logic [GEN_W-1:0]  gen_in;
   logic [GEN_W-1:0]  base;
   logic [PROD_W-1:0] product;
   logic [GEN_W:0]    fold;

   always_comb begin
      base = ctl.restart ? seed : gen_ff;
      // A zero value would lock the generator, so it is replaced.
      if (base == '0) begin
         base = ZERO_SUBST;
      end
      product = PROD_W'(base) * PROD_W'(LCG_MULT);
      // 2^31 is 1 modulo 2^31 - 1, so the high part folds onto the low part.
      fold = {1'b0, product[GEN_W-1:0]} + (GEN_W + 1)'(product[PROD_W-1:GEN_W]);
      if (fold >= {1'b0, LCG_MOD}) begin
         fold = fold - {1'b0, LCG_MOD};
      end
      gen_next = fold[GEN_W-1:0];
      gen_in   = ctl.step ? gen_next : gen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= ZERO_SUBST;
      end else begin
         gen_ff <= gen_in;
      end
   end

endmodule

FILE: rtl/lehmer_keystream_xor.sv
// Top level of the Lehmer keystream XOR block: seed register, input register,
// keystream XOR with byte masking, and the response register.
// Depends on lks_pkg, lks_req_if, lks_rsp_if and lks_gen.

// The block encrypts (or decrypts) a stream of 32-bit words by XORing each one
// with the low KEY_BITS bits of a Park-Miller generator, x' = 16807 * x mod
// (2^31 - 1), that advances exactly once per item. A request item carries the
// word, its count of valid low bytes (bytes at or above the count come back as
// zero, counts above four act as four) and a restart flag that reloads the
// generator from the seed register before the word is processed. The seed is
// written through csr_wr_en/csr_wr_data and only takes effect at the next
// restart; a zero seed, and a generator value of zero, are replaced by
// 0x12345987, which is also the value after reset. An item accepted into the
// input register moves into the response register when that register is empty
// or is being emptied, and its response is presented from there. One item is
// taken every cycle as long as responses are consumed. The generator step (a
// 31 by 15 bit constant multiply and a modulo fold) is combinational and feeds
// the generator register, and that loop sets the clock period.
module lehmer_keystream_xor (
   input  logic                      clock,
   input  logic                      reset,
   lks_req_if.sink                   req_if,
   lks_rsp_if.source                 rsp_if,
   input  logic                      csr_wr_en,
   input  logic [lks_pkg::GEN_W-1:0] csr_wr_data
);
   import lks_pkg::*;

   // Seed register; the generator only reads it on a restart.
   logic [GEN_W-1:0] seed_ff;

   // Input register: one item waiting for the generator.
   logic                a_valid_ff;
   logic                a_valid_in;
   logic [WORD_W-1:0]   a_data_ff;
   logic [NBYTES_W-1:0] a_nbytes_ff;
   logic                a_restart_ff;

   // Response register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic [WORD_W-1:0] rsp_word_in;

   logic              req_fire;
   logic              advance;
   gen_ctl_type       gen_ctl;
   logic [GEN_W-1:0]  gen_next;
   logic [WORD_W-1:0] key;
   logic [WORD_W-1:0] keep;

   // The input register moves on whenever the response register is empty or is
   // being emptied, so a response that is being taken does not stop the next item coming in.
   assign advance      = a_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !a_valid_ff || advance;
   assign req_fire     = req_if.valid && req_if.ready;

   assign gen_ctl.step    = advance;
   assign gen_ctl.restart = a_restart_ff;

   lks_gen u_gen (
      .clock    (clock),
      .reset    (reset),
      .ctl      (gen_ctl),
      .seed     (seed_ff),
      .gen_next (gen_next)
   );

   always_comb begin
      key = {{(WORD_W - KEY_BITS){1'b0}}, gen_next[KEY_BITS-1:0]};
      // Byte lane i survives when it lies below the valid count.
      for (int i = 0; i < NLANES; i++) begin
         keep[8*i +: 8] = {8{NBYTES_W'(i) < a_nbytes_ff}};
      end
      rsp_word_in = (a_data_ff ^ key) & keep;
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (advance) begin
         a_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load on their handshakes and need no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_data_ff    <= req_if.data_word;
         a_nbytes_ff  <= req_if.valid_bytes;
         a_restart_ff <= req_if.restart;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.cipher_word = rsp_word_ff;

endmodule

FILE: dv/lehmer_keystream_xor_test.sv
// Self-checking testbench for lehmer_keystream_xor: drives words through the request
// channel, predicts each keystream-XORed response and compares it on the response channel.
// Depends on lks_pkg, lks_req_if, lks_rsp_if and the lehmer_keystream_xor RTL.
module lehmer_keystream_xor_test;
   import lks_pkg::*;

   // The generator is stepped here with plain 64-bit arithmetic, independent of
   // the fold that the RTL uses.
   localparam longint unsigned MINSTD_MULT = 16807;
   localparam longint unsigned MINSTD_MOD  = 2147483647;
   localparam logic [GEN_W-1:0] KEY_MASK   = GEN_W'((1 << KEY_BITS) - 1);

   // Cycles waited after the last response so that the block is left empty.
   localparam int SETTLE_CYCLES  = 4;
   // The longest quiet stretch in a correct run is the long response hold-off
   // (LONG_HOLD), together with any idle draws.
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset;
   logic             csr_wr_en;
   logic [GEN_W-1:0] csr_wr_data;

   lks_req_if req ();
   lks_rsp_if rsp ();

   lehmer_keystream_xor dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req),
      .rsp_if      (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: the generator value and the seed register as the block
   // should hold them, and the cipher words still owed by the block in order.
   logic [GEN_W-1:0]  gen_value;
   logic [GEN_W-1:0]  seed_value;
   logic [WORD_W-1:0] cipher_expected[$];

   int fail_count  = 0;
   int quiet_cycles = 0;

   // Idle switches for the two sides, and a pending long hold-off of the
   // response side that the receiver process counts down by itself.
   bit src_idle  = 1'b1;
   bit sink_idle = 1'b1;
   int rsp_hold  = 0;

   // One Park-Miller step. A zero value is replaced by the substitute before
   // stepping; a value equal to the modulus steps to zero like any multiple.
   function automatic logic [GEN_W-1:0] minstd_advance(input logic [GEN_W-1:0] v);
      longint unsigned s;
      s = 64'(v);
      if (v == '0)
         s = 64'(ZERO_SUBST);
      return GEN_W'((s * MINSTD_MULT) % MINSTD_MOD);
   endfunction

   // Keep the low valid bytes of a word. A count of zero clears the word and
   // counts above four keep all four lanes.
   function automatic logic [WORD_W-1:0] keep_valid_bytes(input logic [WORD_W-1:0] w,
                                                          input logic [NBYTES_W-1:0] n);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < NLANES; i++)
         if (i < n)
            r[8*i +: 8] = w[8*i +: 8];
      return r;
   endfunction

   // Offer one item, then advance the predictor on the edge where it is taken.
   // The task is entered and left at a falling edge, and valid stays high on
   // exit so that back-to-back items keep the channel busy.
   task automatic send_word(input logic [WORD_W-1:0] data, input logic [NBYTES_W-1:0] nbytes,
                            input logic restart);
      int gap;
      logic [GEN_W-1:0] key;
      gap = src_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         // Junk on the payload while valid is low must be ignored.
         req.valid       <= 1'b0;
         req.data_word   <= $urandom;
         req.valid_bytes <= NBYTES_W'($urandom);
         req.restart     <= 1'($urandom);
         repeat (gap) @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.data_word   <= data;
      req.valid_bytes <= nbytes;
      req.restart     <= restart;
      do
         @(posedge clock);
      while (req.ready !== 1'b1);
      if (restart)
         gen_value = (seed_value == '0) ? ZERO_SUBST : seed_value;
      gen_value = minstd_advance(gen_value);
      key = gen_value & KEY_MASK;
      cipher_expected.push_back(keep_valid_bytes(data ^ WORD_W'(key), nbytes));
      @(negedge clock);
   endtask

   // Stop offering and wait until every expected response has come back, then
   // let the pipeline settle.
   task automatic wait_drained();
      req.valid <= 1'b0;
      while (cipher_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the seed register while the block is idle. It takes effect only at
   // the next restart.
   task automatic write_seed(input logic [GEN_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      seed_value = v;
   endtask

   // Right after reset the generator holds the substitute value and the seed
   // is zero, so a restart also loads the substitute.
   task automatic test_reset_state();
      send_word($urandom, 3'd4, 1'b0);
      send_word($urandom, 3'd4, 1'b0);
      send_word($urandom, 3'd4, 1'b1);
   endtask

   // Every valid-byte count, including zero and the oversized ones; even counts
   // use all-zero data words and odd counts all-one words, and count three restarts.
   task automatic test_field_extremes();
      for (int nb = 0; nb < (1 << NBYTES_W); nb++)
         send_word(nb[0] ? '1 : '0, NBYTES_W'(nb), nb == 3);
   endtask

   // Extreme seeds and a seed write that is not followed by a restart.
   task automatic test_seed_extremes();
      // A seed equal to the modulus steps to zero, and the step after that
      // substitutes the fixed value.
      wait_drained();
      write_seed('1);
      send_word($urandom, 3'd4, 1'b1);
      send_word($urandom, 3'd4, 1'b0);
      send_word($urandom, 3'd4, 1'b0);
      wait_drained();
      write_seed(GEN_W'(1));
      send_word('1, 3'd4, 1'b1);
      // The new seed must not disturb the running generator until a restart.
      wait_drained();
      write_seed({{(GEN_W-1){1'b1}}, 1'b0});
      send_word($urandom, 3'd2, 1'b0);
      send_word($urandom, 3'd4, 1'b0);
      send_word($urandom, 3'd4, 1'b1);
   endtask

   // Mostly well-formed messages: usually a restart on the first word, full words
   // in the middle and a tail word with one to four bytes. The rest is noise with
   // any byte count and random restarts.
   task automatic run_messages(input int n_items);
      int sent;
      int len;
      bit first_restart;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 85) begin
            len = $urandom_range(1, 24);
            first_restart = ($urandom_range(0, 9) < 8);
            for (int i = 0; i < len; i++)
               send_word($urandom,
                         (i == len - 1) ? NBYTES_W'($urandom_range(1, 4)) : NBYTES_W'(4),
                         (i == 0) && first_restart);
            sent += len;
         end else begin
            send_word($urandom, NBYTES_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   // Random streams under several seeds, among them the extremes, and with
   // every combination of idling on the two sides.
   task automatic test_random_streams();
      logic [GEN_W-1:0] seed_pick;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: seed_pick = GEN_W'($urandom);
            1: seed_pick = '0;
            2: seed_pick = '1;
            3: seed_pick = GEN_W'(1);
            default: seed_pick = GEN_W'($urandom);
         endcase
         src_idle  = (phase != 1) && (phase != 3);
         sink_idle = (phase != 1) && (phase != 2);
         wait_drained();
         write_seed(seed_pick);
         run_messages(140);
      end
   endtask

   // The response side holds off for a long stretch while the sender keeps
   // offering back to back, so the block fills and stalls its input. The
   // sender then pauses until every response is in before continuing.
   task automatic test_backpressure();
      src_idle  = 1'b0;
      sink_idle = 1'b0;
      rsp_hold  = LONG_HOLD;
      for (int i = 0; i < 40; i++)
         send_word($urandom, NBYTES_W'($urandom_range(0, 7)), i == 0);
      wait_drained();
      src_idle  = 1'b1;
      sink_idle = 1'b1;
      for (int i = 0; i < 10; i++)
         send_word($urandom, 3'd4, 1'b0);
   endtask

   // Response side: after each taken item it draws a random stall when sink_idle is set.
   // A pending long hold-off overrides the draw and is counted down here.
   initial begin : receiver
      int stall;
      stall = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp.ready <= 1'b0;
            rsp_hold--;
         end else if (stall > 0) begin
            rsp.ready <= 1'b0;
            stall--;
         end else begin
            rsp.ready <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            stall = sink_idle ? $urandom_range(0, 15) : 0;
      end
   end

   // Every response taken is compared with the oldest expected cipher word.
   always @(posedge clock) begin : check_response
      logic [WORD_W-1:0] want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (cipher_expected.size() == 0) begin
            $error("cipher_word: expected none, actual %h", rsp.cipher_word);
            fail_count++;
         end else begin
            want = cipher_expected.pop_front();
            if (rsp.cipher_word !== want) begin
               $error("cipher_word: expected %h, actual %h", want, rsp.cipher_word);
               fail_count++;
            end
         end
      end
   end

   // A run that stops moving in both directions for too long is a failure.
   always @(posedge clock) begin
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req.valid       = 1'b0;
      req.data_word   = '0;
      req.valid_bytes = '0;
      req.restart     = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      gen_value       = ZERO_SUBST;
      seed_value      = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_field_extremes();
      test_seed_extremes();
      test_random_streams();
      test_backpressure();

      wait_drained();
      if (fail_count == 0 && cipher_expected.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
